// ===== rtl/vmds_pkg.sv =====
// Package for the valid-masked descending sorter.
// Holds shared widths, command codes, the cell entry and cell control types
// and the sequencer states. No dependencies.
package vmds_pkg;

	localparam int SLOT_W = 6;
	localparam int KEY_W  = 64;
	localparam int CNT_W  = 7;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_SORT = 1'b1;

	typedef struct packed {
		logic              occ;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  key;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic ins;
		logic pop;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_FLUSH,
		ST_DRAIN
	} state_t;

endpackage

// ===== rtl/vmds_if.sv =====
// Handshake channel interfaces of the sorter: command items in, sorted results out.
// Depends on vmds_pkg for field widths.
interface vmds_in_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [vmds_pkg::SLOT_W-1:0]  slot;
	logic [vmds_pkg::KEY_W-1:0]   key;
	logic                         entry_valid;

	modport source (output valid, cmd, slot, key, entry_valid, input ready);
	modport sink   (input valid, cmd, slot, key, entry_valid, output ready);
endinterface

interface vmds_out_if;
	logic                         valid;
	logic                         ready;
	logic [vmds_pkg::SLOT_W-1:0]  slot_index;
	logic [vmds_pkg::SLOT_W-1:0]  rank;
	logic [vmds_pkg::CNT_W-1:0]   valid_count;
	logic                         empty_res;
	logic                         last;

	modport source (output valid, slot_index, rank, valid_count, empty_res, last, input ready);
	modport sink   (input valid, slot_index, rank, valid_count, empty_res, last, output ready);
endinterface

// ===== rtl/vmds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vmds_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/vmds_cell.sv =====
// One cell of the insertion chain: holds one entry, takes a broadcast entry,
// its upper neighbor's entry on a shift down, or its lower neighbor's on a pop.
// Depends on vmds_pkg.
module vmds_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  vmds_pkg::cell_ctl_t ctl,
	input  vmds_pkg::entry_t    new_ent,
	input  vmds_pkg::entry_t    prev_ent,
	input  logic                prev_take,
	input  vmds_pkg::entry_t    next_ent,
	output vmds_pkg::entry_t    ent,
	output logic                take
);
	import vmds_pkg::*;

	entry_t ent_q;

	// New entry goes ahead of this one on a strictly larger key; ties keep slot order
	assign take = !ent_q.occ || ($signed(new_ent.key) > $signed(ent_q.key));
	assign ent  = ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.clr) begin
			ent_q.occ <= 1'b0;
		end else if (ctl.ins && take) begin
			if (prev_take) begin
				ent_q <= prev_ent;
			end else begin
				ent_q <= new_ent;
			end
		end else if (ctl.pop) begin
			ent_q <= next_ent;
		end
	end
endmodule

// ===== rtl/vmds_chain.sv =====
// Row of sorting cells kept in descending key order, head at cell 0.
// Depends on vmds_pkg and vmds_cell.
module vmds_chain #(
	parameter int N = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vmds_pkg::cell_ctl_t ctl,
	input  vmds_pkg::entry_t    new_ent,
	output vmds_pkg::entry_t    head
);
	import vmds_pkg::*;

	entry_t ent  [N];
	logic   take [N];
	entry_t tail_ent;

	always_comb begin
		tail_ent     = new_ent;
		tail_ent.occ = 1'b0;
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		entry_t prev_e;
		entry_t next_e;
		logic   prev_t;

		if (i == 0) begin : g_first
			assign prev_e = new_ent;
			assign prev_t = 1'b0;
		end else begin : g_mid
			assign prev_e = ent[i-1];
			assign prev_t = take[i-1];
		end

		if (i == N - 1) begin : g_last
			assign next_e = tail_ent;
		end else begin : g_inner
			assign next_e = ent[i+1];
		end

		vmds_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.new_ent   (new_ent),
			.prev_ent  (prev_e),
			.prev_take (prev_t),
			.next_ent  (next_e),
			.ent       (ent[i]),
			.take      (take[i])
		);
	end

	assign head = ent[0];
endmodule

// ===== rtl/valid_masked_descending_sort.sv =====
// Top level of the valid-masked descending sorter: slot key RAM, valid flags,
// sweep sequencer, insertion cell chain and output register.
// Depends on vmds_pkg, vmds_if, vmds_ram, vmds_chain.
//
//   channel  | dir | payload                                          | transfer
//   item     | in  | cmd, slot, key, entry_valid                       | valid && ready
//   result   | out | slot_index, rank, valid_count, empty_res, last    | valid && ready
//
// A load transaction writes the key RAM and the slot's flag.
// A sort reads the key RAM once per slot through its one read port,
// inserts each valid key into the cell chain, passes a flush state for the last
// insert, then pops one result per cycle unless stalled, or one empty result if none.
// Reset clears the valid flags and control state; keys are unknown until written.
// A stalled result holds in the output register; the chain waits behind it.
module valid_masked_descending_sort #(
	parameter int NUM_SLOTS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	vmds_in_if.sink    item,
	vmds_out_if.source result
);
	import vmds_pkg::*;

	localparam int AW = $clog2(NUM_SLOTS);

	state_t            state_q;
	state_t            state_d;
	logic [AW-1:0]     rd_cnt_q;
	logic [NUM_SLOTS-1:0] flags_q;
	logic [NUM_SLOTS-1:0] flag_sh_q;
	logic              ins_vld_s1;
	logic [AW-1:0]     ins_slot_s1;
	logic [CNT_W-1:0]  cnt_q;
	logic [SLOT_W-1:0] rank_q;
	logic              out_vld_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [SLOT_W-1:0] out_rank_q;
	logic [CNT_W-1:0]  out_cnt_q;
	logic              out_empty_q;
	logic              out_last_q;

	logic              acc;
	logic              load_we;
	logic              sort_go;
	logic              sweep_end;
	logic              pop_ok;
	logic              is_last;
	logic              done;
	logic [KEY_W-1:0]  rd_key;
	cell_ctl_t         ctl;
	entry_t            new_ent;
	entry_t            head;

	assign item.ready = (state_q == ST_IDLE);
	assign acc        = item.valid && item.ready;
	assign load_we    = acc && (item.cmd == CMD_LOAD)
	                    && ({1'b0, item.slot} < CNT_W'(NUM_SLOTS));
	assign sort_go    = acc && (item.cmd == CMD_SORT);
	assign sweep_end  = (rd_cnt_q == AW'(NUM_SLOTS - 1));
	assign pop_ok     = (state_q == ST_DRAIN) && (!out_vld_q || result.ready);
	assign is_last    = ((CNT_W'(rank_q) + CNT_W'(1)) == cnt_q);
	assign done       = pop_ok && ((cnt_q == '0) || is_last);

	vmds_ram #(
		.WIDTH (KEY_W),
		.DEPTH (NUM_SLOTS)
	) u_key_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (item.slot[AW-1:0]),
		.wdata (item.key),
		.re    (state_q == ST_SWEEP),
		.raddr (rd_cnt_q),
		.rdata (rd_key)
	);

	always_comb begin
		new_ent.occ  = 1'b1;
		new_ent.slot = SLOT_W'(ins_slot_s1);
		new_ent.key  = rd_key;
		ctl.clr      = sort_go;
		ctl.ins      = ins_vld_s1;
		ctl.pop      = pop_ok && (cnt_q != '0);
	end

	vmds_chain #(
		.N (NUM_SLOTS)
	) u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.new_ent (new_ent),
		.head    (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (sort_go) state_d = ST_SWEEP;
			ST_SWEEP: if (sweep_end) state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_DRAIN;
			ST_DRAIN: if (done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q    <= '0;
			flag_sh_q  <= '0;
			rd_cnt_q   <= '0;
			ins_vld_s1 <= 1'b0;
			cnt_q      <= '0;
			rank_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (load_we) begin
				flags_q[item.slot[AW-1:0]] <= item.entry_valid;
			end
			// snapshot flags, then walk them in step with the RAM reads
			if (sort_go) begin
				flag_sh_q <= flags_q;
			end else if (state_q == ST_SWEEP) begin
				flag_sh_q <= flag_sh_q >> 1;
			end
			if (sort_go) begin
				rd_cnt_q <= '0;
			end else if (state_q == ST_SWEEP && !sweep_end) begin
				rd_cnt_q <= rd_cnt_q + AW'(1);
			end
			ins_vld_s1 <= (state_q == ST_SWEEP) && flag_sh_q[0];
			if (sort_go) begin
				cnt_q <= '0;
			end else if (ins_vld_s1) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (sort_go) begin
				rank_q <= '0;
			end else if (ctl.pop) begin
				rank_q <= rank_q + SLOT_W'(1);
			end
			if (pop_ok) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ins_slot_s1 <= rd_cnt_q;
		if (pop_ok) begin
			if (cnt_q == '0) begin
				out_slot_q  <= '0;
				out_rank_q  <= '0;
				out_cnt_q   <= '0;
				out_empty_q <= 1'b1;
				out_last_q  <= 1'b0;
			end else begin
				out_slot_q  <= head.slot;
				out_rank_q  <= rank_q;
				out_cnt_q   <= cnt_q;
				out_empty_q <= 1'b0;
				out_last_q  <= is_last;
			end
		end
	end

	assign result.valid       = out_vld_q;
	assign result.slot_index  = out_slot_q;
	assign result.rank        = out_rank_q;
	assign result.valid_count = out_cnt_q;
	assign result.empty_res   = out_empty_q;
	assign result.last        = out_last_q;

	// A pop from a non-empty run must find an entry at the head of the chain
	a_head_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> head.occ)
		else $error("pop from empty chain");

	// The run never counts more entries than there are slots
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NUM_SLOTS))
		else $error("valid count out of range");

	// The last result of a run carries the final rank
	a_last_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_last_q) |-> ((CNT_W'(out_rank_q) + CNT_W'(1)) == out_cnt_q))
		else $error("last marker on wrong rank");

	// Input is blocked from a sort command until its run has drained
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		sort_go |=> !item.ready)
		else $error("input accepted during sort");
endmodule
